FILE: rtl/lnu_pkg.sv
// lnu_pkg: widths, register indexes, controller states and the command and
// status structs shared by the layer normalisation unit. No dependencies.
`default_nettype none
package lnu_pkg;

	localparam int SMP_W      = 16;
	localparam int GAIN_W     = 16;
	localparam int OFS_W      = 16;
	localparam int FC_W       = 7;
	localparam int EPS_W      = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam int SUM_W  = 24;
	localparam int MEAN_W = 25;
	localparam int DEV_W  = 26;
	localparam int SQ_W   = 40;
	localparam int VAR_W  = 40;
	localparam int VEPS_W = 41;
	localparam int DIVN_W = 49;
	localparam int INV_W  = 24;
	localparam int P_W    = 35;
	localparam int R_W    = 51;
	localparam int ELEM_W = SMP_W + GAIN_W + OFS_W;

	localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EPSILON       = 8'd1;

	localparam logic [FC_W-1:0]   FC_RESET   = 7'd64;
	localparam logic [EPS_W-1:0]  EPS_RESET  = 16'd1;
	localparam logic [DIVN_W-1:0] LIMIT_ZERO = 49'h1_0000_0000_0000;

	typedef enum logic [1:0] {
		DIV_MEAN,
		DIV_VAR,
		DIV_INV
	} div_sel_t;

	typedef enum logic [3:0] {
		S_IN,
		S_MEAN_GO,
		S_MEAN_WAIT,
		S_SQ_RD,
		S_SQ_ACC,
		S_VAR_GO,
		S_VAR_WAIT,
		S_INV_GO,
		S_INV_WAIT,
		S_ROOT,
		S_OUT_RD,
		S_OUT_M1,
		S_OUT_M2,
		S_OUT_FIN,
		S_OUT_EMIT
	} state_t;

	typedef struct packed {
		logic     take;
		logic     tok_clr;
		logic     idx_clr;
		logic     idx_inc;
		logic     rd;
		logic     sq_clr;
		logic     sq_acc;
		logic     div_start;
		div_sel_t div_sel;
		logic     mean_load;
		logic     var_load;
		logic     root_start;
		logic     inv_load;
		logic     p_load;
		logic     r_load;
		logic     y_load;
	} cmd_t;

	typedef struct packed {
		logic token_full;
		logic div_done;
		logic root_done;
		logic idx_last;
	} status_t;

endpackage
`default_nettype wire

FILE: rtl/lnu_if.sv
// lnu_if: request channels of the layer normalisation unit (element input,
// result output, register write). Depends on lnu_pkg for field widths.
`default_nettype none
interface lnu_in_if;
	logic                      valid;
	logic                      ready;
	logic signed [15:0]        sample;
	logic signed [15:0]        gain;
	logic signed [15:0]        offset;
	modport source (output valid, sample, gain, offset, input ready);
	modport sink (input valid, sample, gain, offset, output ready);
endinterface

interface lnu_out_if;
	logic                      valid;
	logic                      ready;
	logic signed [15:0]        normalized;
	logic                      last_of_token;
	modport source (output valid, normalized, last_of_token, input ready);
	modport sink (input valid, normalized, last_of_token, output ready);
endinterface

interface lnu_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [lnu_pkg::CFG_IDX_W-1:0]  index;
	logic [lnu_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/lnu_ctrl.sv
// lnu_ctrl: sequencer of the layer normalisation unit. Issues datapath
// commands per state. Depends on lnu_pkg.
`default_nettype none
module lnu_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             feed_valid,
	output logic                  feed_ready,
	output logic                  result_valid,
	input  wire logic             result_ready,
	input  wire lnu_pkg::status_t status,
	output lnu_pkg::cmd_t         cmd
);
	import lnu_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.div_sel  = DIV_MEAN;
		feed_ready   = 1'b0;
		result_valid = 1'b0;
		unique case (state_q)
			S_IN: begin
				feed_ready = 1'b1;
				if (feed_valid) begin
					cmd.take = 1'b1;
					if (status.token_full) state_d = S_MEAN_GO;
				end
			end
			S_MEAN_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_MEAN;
				state_d       = S_MEAN_WAIT;
			end
			S_MEAN_WAIT: begin
				if (status.div_done) begin
					cmd.mean_load = 1'b1;
					cmd.idx_clr   = 1'b1;
					cmd.sq_clr    = 1'b1;
					state_d       = S_SQ_RD;
				end
			end
			S_SQ_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_SQ_ACC;
			end
			S_SQ_ACC: begin
				cmd.sq_acc = 1'b1;
				if (status.idx_last) begin
					state_d = S_VAR_GO;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SQ_RD;
				end
			end
			S_VAR_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_VAR;
				state_d       = S_VAR_WAIT;
			end
			S_VAR_WAIT: begin
				if (status.div_done) begin
					cmd.var_load = 1'b1;
					state_d      = S_INV_GO;
				end
			end
			S_INV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_INV;
				state_d       = S_INV_WAIT;
			end
			S_INV_WAIT: begin
				if (status.div_done) begin
					cmd.root_start = 1'b1;
					state_d        = S_ROOT;
				end
			end
			S_ROOT: begin
				if (status.root_done) begin
					cmd.inv_load = 1'b1;
					cmd.idx_clr  = 1'b1;
					state_d      = S_OUT_RD;
				end
			end
			S_OUT_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_OUT_M1;
			end
			S_OUT_M1: begin
				cmd.p_load = 1'b1;
				state_d    = S_OUT_M2;
			end
			S_OUT_M2: begin
				cmd.r_load = 1'b1;
				state_d    = S_OUT_FIN;
			end
			S_OUT_FIN: begin
				cmd.y_load = 1'b1;
				state_d    = S_OUT_EMIT;
			end
			S_OUT_EMIT: begin
				result_valid = 1'b1;
				if (result_ready) begin
					if (status.idx_last) begin
						cmd.tok_clr = 1'b1;
						state_d     = S_IN;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_OUT_RD;
					end
				end
			end
			default: begin
				state_d = S_IN;
			end
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/lnu_dp.sv
// lnu_dp: datapath of the layer normalisation unit: element store, sums,
// shared iterative divider, bit-serial inverse root and output pipeline.
// Depends on lnu_pkg.
`default_nettype none
module lnu_dp #(
	parameter int MAX_FEATURES = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	input  wire logic [lnu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lnu_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic signed [lnu_pkg::SMP_W-1:0]   sample,
	input  wire logic signed [lnu_pkg::GAIN_W-1:0]  gain,
	input  wire logic signed [lnu_pkg::OFS_W-1:0]   offset,
	input  wire lnu_pkg::cmd_t                      cmd,
	output lnu_pkg::status_t                        status,
	output logic signed [lnu_pkg::SMP_W-1:0]        normalized,
	output logic                                    last_of_token
);
	import lnu_pkg::*;

	localparam int AW = $clog2(MAX_FEATURES);
	localparam int CW = $clog2(MAX_FEATURES + 1);
	localparam int DCW = $clog2(DIVN_W);
	localparam int RBW = $clog2(INV_W);

	// registers
	logic [FC_W-1:0]  fc_q;
	logic [EPS_W-1:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q  <= FC_RESET;
			eps_q <= EPS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FEATURE_COUNT: fc_q  <= cfg_data[FC_W-1:0];
				CFG_EPSILON:       eps_q <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	// element store
	logic [ELEM_W-1:0] mem [MAX_FEATURES];
	logic [ELEM_W-1:0] rd_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     idx_q;

	always_ff @(posedge clk) begin
		if (cmd.take) mem[count_q[AW-1:0]] <= {sample, gain, offset};
		if (cmd.rd) rd_q <= mem[idx_q];
	end

	logic signed [SUM_W-1:0] sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.tok_clr) begin
				count_q <= '0;
				sum_q   <= '0;
			end else if (cmd.take) begin
				count_q <= count_q + CW'(1);
				sum_q   <= sum_q + SUM_W'(sample);
			end
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + AW'(1);
		end
	end

	logic [FC_W-1:0] eff;
	logic [FC_W-1:0] n_next;
	always_comb begin
		if (fc_q == '0) eff = FC_W'(1);
		else if (fc_q > FC_W'(MAX_FEATURES)) eff = FC_W'(MAX_FEATURES);
		else eff = fc_q;
		n_next = FC_W'(count_q) + FC_W'(1);
	end

	assign status.token_full = (n_next >= eff) || (n_next >= FC_W'(MAX_FEATURES));
	assign status.idx_last   = (CW'(idx_q) + CW'(1)) == count_q;

	// deviation of the element read back
	logic signed [SMP_W-1:0]  rd_sample;
	logic signed [23:0]       smp_sh;
	logic signed [MEAN_W-1:0] mean_q;
	logic signed [DEV_W-1:0]  dev;
	logic signed [2*DEV_W-1:0] dsq;
	assign rd_sample = rd_q[ELEM_W-1 -: SMP_W];
	assign smp_sh    = {rd_sample, 8'd0};
	assign dev       = DEV_W'(smp_sh) - DEV_W'(mean_q);
	assign dsq       = dev * dev;

	logic [SQ_W-1:0]  sq_q;
	logic [VAR_W-1:0] var_q;
	logic [VEPS_W-1:0] veps;
	assign veps = VEPS_W'(var_q) + VEPS_W'(eps_q);

	always_ff @(posedge clk) begin
		if (cmd.sq_clr) sq_q <= '0;
		else if (cmd.sq_acc) sq_q <= sq_q + SQ_W'(dsq[2*DEV_W-1:16]);
	end

	// shared restoring divider, one quotient bit per cycle
	logic [VEPS_W-1:0] div_rem_q;
	logic [DIVN_W-1:0] div_quo_q;
	logic [VEPS_W-1:0] div_dsr_q;
	logic [DCW-1:0]    div_cnt_q;
	logic              div_busy_q;
	logic              div_done_q;
	logic [VEPS_W:0]   div_trial;
	logic              div_ge;
	logic              sum_neg;
	logic [SUM_W-1:0]  sum_mag;
	logic [DIVN_W-1:0] div_dnd;
	logic [VEPS_W-1:0] div_dsr;

	assign sum_neg   = sum_q[SUM_W-1];
	assign sum_mag   = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign div_trial = {div_rem_q, div_quo_q[DIVN_W-1]};
	assign div_ge    = div_trial >= {1'b0, div_dsr_q};

	always_comb begin
		div_dnd = '0;
		div_dsr = VEPS_W'(count_q);
		case (cmd.div_sel)
			DIV_MEAN: div_dnd = (DIVN_W'(sum_mag) << 8) + DIVN_W'(count_q >> 1);
			DIV_VAR:  div_dnd = DIVN_W'(sq_q);
			DIV_INV: begin
				div_dnd = LIMIT_ZERO;
				div_dsr = veps;
			end
			default: div_dnd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			div_done_q <= 1'b0;
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				div_cnt_q  <= '0;
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q + DCW'(1);
				if (div_cnt_q == DCW'(DIVN_W - 1)) begin
					div_busy_q <= 1'b0;
					div_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_rem_q <= '0;
			div_quo_q <= div_dnd;
			div_dsr_q <= div_dsr;
		end else if (div_busy_q) begin
			div_rem_q <= div_ge ? VEPS_W'(div_trial - {1'b0, div_dsr_q})
				: VEPS_W'(div_trial);
			div_quo_q <= {div_quo_q[DIVN_W-2:0], div_ge};
		end
	end

	assign status.div_done = div_done_q;

	// bit-serial inverse root: largest y with y*y <= limit
	logic [DIVN_W-1:0]  root_lim_q;
	logic [INV_W-1:0]   root_y_q;
	logic [RBW-1:0]     root_b_q;
	logic               root_busy_q;
	logic               root_done_q;
	logic [INV_W-1:0]   root_c;
	logic [2*INV_W-1:0] root_cc;
	assign root_c  = root_y_q | (INV_W'(1) << root_b_q);
	assign root_cc = root_c * root_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_busy_q <= 1'b0;
			root_done_q <= 1'b0;
			root_b_q    <= '0;
		end else begin
			root_done_q <= 1'b0;
			if (cmd.root_start) begin
				root_busy_q <= 1'b1;
				root_b_q    <= RBW'(INV_W - 1);
			end else if (root_busy_q) begin
				if (root_b_q == '0) begin
					root_busy_q <= 1'b0;
					root_done_q <= 1'b1;
				end else begin
					root_b_q <= root_b_q - RBW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.root_start) begin
			root_y_q   <= '0;
			root_lim_q <= (veps == '0) ? LIMIT_ZERO : div_quo_q;
		end else if (root_busy_q) begin
			if (DIVN_W'(root_cc) <= root_lim_q) root_y_q <= root_c;
		end
	end

	assign status.root_done = root_done_q;

	logic [INV_W-1:0] inv_q;
	logic [MEAN_W-1:0] q_mean;
	assign q_mean = MEAN_W'(div_quo_q);

	always_ff @(posedge clk) begin
		if (cmd.mean_load) mean_q <= sum_neg ? -signed'(q_mean) : signed'(q_mean);
		if (cmd.var_load) var_q <= VAR_W'(div_quo_q);
		if (cmd.inv_load) inv_q <= root_y_q;
	end

	// output pipeline
	logic signed [DEV_W+INV_W:0]   pm;
	logic signed [INV_W:0]         inv_s;
	logic signed [P_W-1:0]         p_s1;
	logic signed [GAIN_W-1:0]      gain_s1;
	logic signed [OFS_W-1:0]       ofs_s1;
	logic signed [OFS_W-1:0]       ofs_s2;
	logic signed [R_W-1:0]         rm;
	logic signed [R_W-1:0]         r_s2;
	logic signed [R_W-1:0]         r_rnd;
	logic signed [R_W-21:0]        y_sh;
	logic signed [R_W-20:0]        y_sum;
	logic signed [SMP_W-1:0]       y_sat;

	assign inv_s = {1'b0, inv_q};
	assign pm    = dev * inv_s;
	assign rm    = p_s1 * gain_s1;
	assign r_rnd = r_s2 + R_W'(1 << 19);
	assign y_sh  = (R_W-20)'(r_rnd >>> 20);
	assign y_sum = (R_W-19)'(y_sh) + (R_W-19)'(ofs_s2);

	always_comb begin
		if (y_sum > (R_W-19)'(32767)) y_sat = 16'sh7FFF;
		else if (y_sum < -(R_W-19)'(32768)) y_sat = -16'sh8000;
		else y_sat = SMP_W'(y_sum);
	end

	always_ff @(posedge clk) begin
		if (cmd.p_load) begin
			p_s1    <= P_W'(pm >>> 16);
			gain_s1 <= rd_q[GAIN_W+OFS_W-1 -: GAIN_W];
			ofs_s1  <= rd_q[OFS_W-1:0];
		end
		if (cmd.r_load) begin
			r_s2   <= rm;
			ofs_s2 <= ofs_s1;
		end
		if (cmd.y_load) begin
			normalized    <= y_sat;
			last_of_token <= status.idx_last;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/layer_norm_unit.sv
// layer_norm_unit: top level, joins lnu_ctrl and lnu_dp to the request
// channels. Depends on lnu_pkg, lnu_if, lnu_ctrl and lnu_dp.
//
//  channel  dir  payload                       request on
//  feed     in   sample, gain, offset          valid && ready
//  result   out  normalized, last_of_token     valid && ready
//  cfg      in   index, data                   valid && ready (always ready)
//
// a token of n elements is loaded, then worked out in three passes of the
// one-bit-per-cycle divider (mean, variance, inverse), the root steps and
// two store reads per element; each result then passes OUT_RD, OUT_M1,
// OUT_M2 and OUT_FIN and waits in OUT_EMIT for result.ready
// no request is taken on feed while a token is being worked out or emitted
// reset clears counts, the sample sum and state; the element store is not cleared
`default_nettype none
module layer_norm_unit #(
	parameter int MAX_FEATURES = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lnu_in_if.sink    feed,
	lnu_out_if.source result,
	lnu_cfg_if.sink   cfg
);
	import lnu_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg.ready = 1'b1;

	lnu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.feed_valid   (feed.valid),
		.feed_ready   (feed.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.status       (status),
		.cmd          (cmd)
	);

	lnu_dp #(
		.MAX_FEATURES (MAX_FEATURES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.sample        (feed.sample),
		.gain          (feed.gain),
		.offset        (feed.offset),
		.cmd           (cmd),
		.status        (status),
		.normalized    (result.normalized),
		.last_of_token (result.last_of_token)
	);

`ifndef NO_ASSERTIONS
	a_no_feed_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !feed.ready)
		else $error("feed ready while a result is pending");

	a_back_to_feed: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && result.last_of_token) |=> feed.ready)
		else $error("not accepting after last result of token");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !status.div_done)
		else $error("divider finished straight after start");
`endif
endmodule
`default_nettype wire
